// File: rtl/core/rtcf_pkg.sv
package rtcf_pkg;

  // RGB565 layout
  localparam int unsigned PIX_W = 16;
  localparam int unsigned RED_W = 5;
  localparam int unsigned GRN_W = 6;
  localparam int unsigned BLU_W = 5;
  localparam int unsigned RED_LSB = 11;
  localparam int unsigned GRN_LSB = 5;
  localparam int unsigned BLU_LSB = 0;

  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ORIGIN_W = 13;
  localparam int unsigned SIZE_W = 8;

  // configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_FADE_ALPHA    = 2'd2
  } cfg_reg_t;

endpackage

// File: rtl/core/rgb565_tile_clip_fade.sv
// Tile pixel clipper and fader. Takes one RGB565 tile pixel per beat in raster
// order (tile_start marks the first pixel of a tile) and returns zero or one
// beat per pixel: the on-screen pixel with its screen coordinates, each color
// channel scaled by fade_alpha/255, and tlast on the last visible pixel of the
// tile. Pixels outside the tile or off screen are dropped, as are all pixels
// of a tile whose clipped area exceeds TILE_CAPACITY (unless the tile is fully
// on screen at full alpha). A pixel is accepted every clock unless the output
// stalls; each result passes the clipping register and then the area-check
// and fade output register. Change the screen size and alpha registers only
// while no beat is in flight.
module rgb565_tile_clip_fade #(
  parameter int unsigned TILE_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // tile pixels in
  input  logic        in_tvalid,
  output logic        in_tready,
  // tile_origin_x[12:0], tile_origin_y[25:13], tile_width[33:26],
  // tile_height[41:34], source_pixel[57:42], zero [63:58]
  input  logic [63:0] in_tdata,
  // tile_start[0]
  input  logic        in_tuser,
  // screen pixels out
  output logic        out_tvalid,
  input  logic        out_tready,
  // screen_x[11:0], screen_y[23:12], faded_pixel[39:24]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  localparam int unsigned CW = rtcf_pkg::COORD_W;
  localparam int unsigned SW = rtcf_pkg::SIZE_W;
  localparam int unsigned PW = rtcf_pkg::PIX_W;

  // ---------------- configuration registers ----------------
  logic [CW-1:0]                 screen_w_r, screen_h_r;
  logic [rtcf_pkg::ALPHA_W-1:0]  fade_alpha_r;
  rtcf_pkg::cfg_reg_t            cfg_sel;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = rtcf_pkg::cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r   <= CW'(320);
      screen_h_r   <= CW'(240);
      fade_alpha_r <= '1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        rtcf_pkg::REG_SCREEN_WIDTH:  screen_w_r   <= cfg_pwdata[CW-1:0];
        rtcf_pkg::REG_SCREEN_HEIGHT: screen_h_r   <= cfg_pwdata[CW-1:0];
        rtcf_pkg::REG_FADE_ALPHA:    fade_alpha_r <= cfg_pwdata[rtcf_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      rtcf_pkg::REG_SCREEN_WIDTH:  cfg_prdata = 32'(screen_w_r);
      rtcf_pkg::REG_SCREEN_HEIGHT: cfg_prdata = 32'(screen_h_r);
      rtcf_pkg::REG_FADE_ALPHA:    cfg_prdata = 32'(fade_alpha_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- input fields ----------------
  logic signed [rtcf_pkg::ORIGIN_W-1:0] org_x, org_y;
  logic [SW-1:0]                        tile_w, tile_h;
  logic [PW-1:0]                        src_pix;
  logic                                 in_beat;

  assign org_x   = in_tdata[12:0];
  assign org_y   = in_tdata[25:13];
  assign tile_w  = in_tdata[33:26];
  assign tile_h  = in_tdata[41:34];
  assign src_pix = in_tdata[57:42];
  assign in_beat = in_tvalid & in_tready;

  // ---------------- tile counters ----------------
  logic [SW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [SW-1:0] col_cur, row_cur, col_inc;
  logic          in_tile;

  always_comb begin
    col_cur = in_tuser ? '0 : col_r;
    row_cur = in_tuser ? '0 : row_r;
    in_tile = (col_cur < tile_w) && (row_cur < tile_h);
    col_inc = col_cur + SW'(1);
    col_nxt = col_cur;
    row_nxt = row_cur;
    if (tile_w != '0) begin
      if (col_inc >= tile_w) begin
        col_nxt = '0;
        row_nxt = (row_cur == '1) ? row_cur : row_cur + SW'(1);
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_beat) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- clipping (stage 1) ----------------
  logic signed [13:0] pos_x, pos_y, end_x, end_y, clip_x1, clip_y1;
  logic signed [13:0] clip_x0, clip_y0, span_x, span_y, scr_w, scr_h;
  logic               on_screen, fully_in;

  always_comb begin
    scr_w   = $signed({2'b00, screen_w_r});
    scr_h   = $signed({2'b00, screen_h_r});
    pos_x   = $signed({org_x[12], org_x}) + $signed({6'd0, col_cur});
    pos_y   = $signed({org_y[12], org_y}) + $signed({6'd0, row_cur});
    end_x   = $signed({org_x[12], org_x}) + $signed({6'd0, tile_w});
    end_y   = $signed({org_y[12], org_y}) + $signed({6'd0, tile_h});
    clip_x0 = org_x[12] ? 14'sd0 : $signed({1'b0, org_x});
    clip_y0 = org_y[12] ? 14'sd0 : $signed({1'b0, org_y});
    clip_x1 = (end_x > scr_w) ? scr_w : end_x;
    clip_y1 = (end_y > scr_h) ? scr_h : end_y;
    span_x  = clip_x1 - clip_x0;
    span_y  = clip_y1 - clip_y0;
    on_screen = !pos_x[13] && !pos_y[13] && (pos_x < scr_w) && (pos_y < scr_h);
    fully_in  = (fade_alpha_r == '1) && !org_x[12] && !org_y[12] &&
                (end_x <= scr_w) && (end_y <= scr_h);
  end

  logic          s1_valid_r;
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic [SW-1:0] s1_span_x_r, s1_span_y_r;
  logic          s1_fast_r, s1_last_r;
  logic [PW-1:0] s1_pix_r;
  logic          s1_go;

  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_beat & in_tile & on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_x_r      <= pos_x[CW-1:0];
      s1_y_r      <= pos_y[CW-1:0];
      // a visible pixel's clipped span is 1..tile size, so 8 bits hold it
      s1_span_x_r <= span_x[SW-1:0];
      s1_span_y_r <= span_y[SW-1:0];
      s1_fast_r   <= fully_in;
      s1_last_r   <= (pos_x == clip_x1 - 14'sd1) && (pos_y == clip_y1 - 14'sd1);
      s1_pix_r    <= src_pix;
    end
  end

  // ---------------- area check and fade (stage 2) ----------------
  logic [2*SW-1:0] area;
  logic            keep;
  logic [PW-1:0]   faded;

  assign area = (2*SW)'(s1_span_x_r) * (2*SW)'(s1_span_y_r);
  assign keep = s1_fast_r || ({1'b0, area} <= (2*SW+1)'(TILE_CAPACITY));

  rtcf_fade u_fade (
    .pixel_in  (s1_pix_r),
    .alpha     (fade_alpha_r),
    .pixel_out (faded)
  );

  logic          out_valid_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic [PW-1:0] out_pix_r;
  logic          out_last_r;

  assign s1_go = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid_r) begin
      out_x_r    <= s1_x_r;
      out_y_r    <= s1_y_r;
      out_pix_r  <= faded;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/core/rtcf_fade.sv
module rtcf_fade (
  input  logic [rtcf_pkg::PIX_W-1:0]   pixel_in,
  input  logic [rtcf_pkg::ALPHA_W-1:0] alpha,
  output logic [rtcf_pkg::PIX_W-1:0]   pixel_out
);

  // c * alpha / 255, truncated; exact for products below 255*256
  function automatic logic [5:0] scale(input logic [5:0] c, input logic [7:0] a);
    logic [13:0] p;
    logic [14:0] s;
    p = 14'(c) * 14'(a);
    s = 15'(p) + 15'(p[13:8]) + 15'd1;
    return s[13:8];
  endfunction

  logic [5:0] red_s, grn_s, blu_s;

  always_comb begin
    red_s = scale({1'b0, pixel_in[rtcf_pkg::RED_LSB +: rtcf_pkg::RED_W]}, alpha);
    grn_s = scale(pixel_in[rtcf_pkg::GRN_LSB +: rtcf_pkg::GRN_W], alpha);
    blu_s = scale({1'b0, pixel_in[rtcf_pkg::BLU_LSB +: rtcf_pkg::BLU_W]}, alpha);
    pixel_out = {red_s[rtcf_pkg::RED_W-1:0], grn_s, blu_s[rtcf_pkg::BLU_W-1:0]};
  end

endmodule

// File: bench/tb.sv
module tb;

  localparam int TILE_CAP = 256;

  typedef struct {
    logic signed [rtcf_pkg::ORIGIN_W-1:0] ox;
    logic signed [rtcf_pkg::ORIGIN_W-1:0] oy;
    logic [rtcf_pkg::SIZE_W-1:0]          tw;
    logic [rtcf_pkg::SIZE_W-1:0]          th;
    logic                                 start;
    logic [rtcf_pkg::PIX_W-1:0]           src;
  } tile_pix_t;

  typedef struct {
    logic [rtcf_pkg::COORD_W-1:0] sx;
    logic [rtcf_pkg::COORD_W-1:0] sy;
    logic [rtcf_pkg::PIX_W-1:0]   pix;
    logic                         last;
  } screen_pix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // tile_origin_x[12:0], tile_origin_y[25:13], tile_width[33:26],
  // tile_height[41:34], source_pixel[57:42], zero [63:58]
  logic [63:0] in_tdata = '0;
  // tile_start[0]
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // screen_x[11:0], screen_y[23:12], faded_pixel[39:24]
  logic [39:0] out_tdata;
  logic        out_tlast;

  // predictor copy of the registers and tile counters
  int          scr_w = 320;
  int          scr_h = 240;
  int          fade = 255;
  logic [7:0]  col_cnt = '0;
  logic [7:0]  row_cnt = '0;

  screen_pix_t screen_pix_q[$];
  int          fail_cnt = 0;
  bit          no_idle = 1'b0;
  int          out_stall = 0;

  rgb565_tile_clip_fade #(.TILE_CAPACITY(TILE_CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [rtcf_pkg::ORIGIN_W-1:0] pick_origin(int span, int size);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 8191)) - 4096;
      1: v = span - int'($urandom_range(0, size));
      default: v = int'($urandom_range(0, span + size)) - size;
    endcase
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return rtcf_pkg::ORIGIN_W'(v);
  endfunction

  task automatic clip_and_fade(input tile_pix_t p);
    int ox, oy, tw, th, col, row, sx, sy, x0, y0, x1, y1, r, g, b;
    bit fast;
    screen_pix_t res;
    ox = p.ox;
    oy = p.oy;
    tw = p.tw;
    th = p.th;
    if (p.start) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    col = col_cnt;
    row = row_cnt;
    // advance the raster position; row saturates
    if (tw != 0) begin
      col_cnt = col_cnt + 8'd1;
      if (col_cnt >= tw) begin
        col_cnt = '0;
        if (row_cnt != 8'd255) row_cnt = row_cnt + 8'd1;
      end
    end
    if (col >= tw || row >= th) return;
    sx = ox + col;
    sy = oy + row;
    if (sx < 0 || sy < 0 || sx >= scr_w || sy >= scr_h) return;
    x0 = ox < 0 ? 0 : ox;
    y0 = oy < 0 ? 0 : oy;
    x1 = ox + tw;
    y1 = oy + th;
    if (x1 > scr_w) x1 = scr_w;
    if (y1 > scr_h) y1 = scr_h;
    // fully on screen at full alpha bypasses the area limit
    fast = fade == 255 && ox >= 0 && oy >= 0 && ox + tw <= scr_w && oy + th <= scr_h;
    if (!fast && (x1 - x0) * (y1 - y0) > TILE_CAP) return;
    r = int'(p.src[15:11]) * fade / 255;
    g = int'(p.src[10:5]) * fade / 255;
    b = int'(p.src[4:0]) * fade / 255;
    res.sx = sx[rtcf_pkg::COORD_W-1:0];
    res.sy = sy[rtcf_pkg::COORD_W-1:0];
    res.pix = {r[rtcf_pkg::RED_W-1:0], g[rtcf_pkg::GRN_W-1:0], b[rtcf_pkg::BLU_W-1:0]};
    res.last = sx == x1 - 1 && sy == y1 - 1;
    screen_pix_q.push_back(res);
  endtask

  task automatic send_pixel(input tile_pix_t p);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'b0, p.src, p.th, p.tw, p.oy, p.ox};
    in_tuser = p.start;
    do @(posedge clk); while (!in_tready);
    clip_and_fade(p);
  endtask

  task automatic send_tile(input logic signed [rtcf_pkg::ORIGIN_W-1:0] ox, oy,
                           input logic [rtcf_pkg::SIZE_W-1:0] tw, th, input int n,
                           input bit first_start, input bit mutate);
    logic [rtcf_pkg::PIX_W-1:0] src;
    logic [rtcf_pkg::SIZE_W-1:0] w, h;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      src = pick == 0 ? 16'hFFFF : pick == 1 ? 16'h0000 : 16'($urandom);
      w = tw;
      h = th;
      // change the size in mid tile now and then
      if (mutate && i > 0 && $urandom_range(0, 29) == 0) begin
        w = 8'($urandom);
        h = 8'($urandom);
      end
      send_pixel('{ox, oy, w, h, first_start && i == 0, src});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (screen_pix_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input rtcf_pkg::cfg_reg_t idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = idx == rtcf_pkg::REG_FADE_ALPHA ? 32'hFF : 32'hFFF;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      rtcf_pkg::REG_SCREEN_WIDTH:  scr_w = val & mask;
      rtcf_pkg::REG_SCREEN_HEIGHT: scr_h = val & mask;
      default:                     fade = val & mask;
    endcase
    // read back
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & mask) != (val & mask)) begin
      $error("prdata[%0d]: expected %0d, got %0d", idx, val & mask, cfg_prdata & mask);
      fail_cnt++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_screen(input int w, h, a);
    drain();
    write_reg(rtcf_pkg::REG_SCREEN_WIDTH, w);
    write_reg(rtcf_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(rtcf_pkg::REG_FADE_ALPHA, a);
  endtask

  task automatic test_directed_clipping();
    send_tile(0, 0, 2, 2, 4, 1, 0);
    send_tile(318, 238, 3, 3, 9, 1, 0);
    send_tile(-2, -1, 3, 2, 6, 1, 0);
    // two beats past the end of a one-pixel tile
    send_tile(319, 239, 1, 1, 3, 1, 0);
    send_pixel('{13'sd10, 13'sd10, 8'd0, 8'd5, 1'b1, 16'hFFFF});
    send_pixel('{13'sd10, 13'sd10, 8'd5, 8'd0, 1'b1, 16'hFFFF});
    send_pixel('{-13'sd4096, 13'sd4095, 8'd255, 8'd255, 1'b1, 16'hFFFF});
    send_pixel('{13'sd4095, -13'sd4096, 8'd255, 8'd255, 1'b1, 16'h0000});
  endtask

  task automatic test_fade_levels();
    int levels[4] = '{0, 1, 128, 254};
    foreach (levels[i]) begin
      set_screen(320, 240, levels[i]);
      send_tile(5, 5, 2, 2, 4, 1, 0);
    end
  endtask

  task automatic test_tile_capacity();
    set_screen(320, 240, 255);
    no_idle = 1'b1;
    send_tile(0, 0, 17, 16, 272, 1, 0);
    no_idle = 1'b0;
    set_screen(320, 240, 200);
    send_tile(5, 5, 17, 16, 272, 1, 0);
    // clips to exactly the capacity
    send_tile(-1, -1, 17, 17, 289, 1, 0);
  endtask

  task automatic test_empty_screen();
    set_screen(0, 240, 255);
    send_tile(0, 0, 3, 3, 9, 1, 0);
    set_screen(320, 0, 255);
    send_tile(0, 0, 3, 3, 9, 1, 0);
    set_screen(1, 1, 255);
    send_tile(0, 0, 2, 2, 4, 1, 0);
  endtask

  task automatic random_phase(input int w, h, a, budget);
    int sent, n, kind;
    logic [rtcf_pkg::SIZE_W-1:0] tw, th;
    logic signed [rtcf_pkg::ORIGIN_W-1:0] ox, oy;
    set_screen(w, h, a);
    sent = 0;
    while (sent < budget) begin
      no_idle = $urandom_range(0, 3) == 0;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        n = $urandom_range(1, 5);
        repeat (n)
          send_pixel('{13'($urandom), 13'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(0, 3) == 0, 16'($urandom)});
      end else begin
        case (kind)
          3: begin tw = $urandom_range(128, 255); th = 1; end
          4: begin tw = 1; th = $urandom_range(128, 255); end
          5: begin tw = $urandom_range(17, 20); th = $urandom_range(17, 20); end
          default: begin tw = $urandom_range(1, 12); th = $urandom_range(1, 12); end
        endcase
        ox = pick_origin(scr_w, tw);
        oy = pick_origin(scr_h, th);
        n = tw * th;
        case ($urandom_range(0, 9))
          0: n = $urandom_range(1, n);
          1: n = n + $urandom_range(1, 4);
          default: ;
        endcase
        send_tile(ox, oy, tw, th, n, $urandom_range(0, 15) != 0, $urandom_range(0, 4) == 0);
      end
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_tiles();
    random_phase(320, 240, 255, 50);
    random_phase(4095, 4095, $urandom_range(1, 254), 50);
    random_phase(40, 30, 0, 50);
    random_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 255), 50);
    random_phase(4095, 4095, 255, 50);
  endtask

  // result side backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready = 1'b0;
      out_stall--;
    end else begin
      out_tready = 1'b1;
      out_stall = pick_gap();
    end
  end

  always @(posedge clk) begin : check_beat
    screen_pix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (screen_pix_q.size() == 0) begin
        $error("unexpected beat: screen_x %0d screen_y %0d", out_tdata[11:0], out_tdata[23:12]);
        fail_cnt++;
      end else begin
        want = screen_pix_q.pop_front();
        if (out_tdata[11:0] !== want.sx) begin
          $error("screen_x: expected %0d, got %0d", want.sx, out_tdata[11:0]);
          fail_cnt++;
        end
        if (out_tdata[23:12] !== want.sy) begin
          $error("screen_y: expected %0d, got %0d", want.sy, out_tdata[23:12]);
          fail_cnt++;
        end
        if (out_tdata[39:24] !== want.pix) begin
          $error("faded_pixel: expected %h, got %h", want.pix, out_tdata[39:24]);
          fail_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last_in_tile: expected %0d, got %0d", want.last, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_clipping();
    test_fade_levels();
    test_tile_capacity();
    test_empty_screen();
    test_random_tiles();
    drain();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
